FILE: src/mfb_pkg.sv
`timescale 1ns / 1ps

package mfb_pkg;

   // Default panel size
   localparam int DEFAULT_COLUMNS = 84;
   localparam int DEFAULT_ROWS    = 48;

   // Fixed field widths
   localparam int CMD_W   = 2;
   localparam int POS_W   = 9;
   localparam int SIZE_W  = 8;
   localparam int COORD_W = 8;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 9;
   localparam int BANK_W  = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_RECT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_SWEEP,
      JOB_READ
   } job_kind_type;

   // One classified command, as held in the queue
   typedef struct packed {
      job_kind_type         kind;
      logic [CMD_W-1:0]     cmd;
      logic [COORD_W-1:0]   x_first;
      logic [COORD_W-1:0]   x_last;
      logic [COORD_W-1:0]   y_first;
      logic [COORD_W-1:0]   y_last;
      logic [BYTE_W-1:0]    value;
      logic [INDEX_W-1:0]   read_addr;
      logic                 read_hit;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_REPLY
   } back_state_type;

endpackage

FILE: src/mfb_ram.sv
`timescale 1ns / 1ps

module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mfb_front.sv
`timescale 1ns / 1ps

module mfb_front
   import mfb_pkg::*;
#(
   parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
   parameter int DISPLAY_ROWS    = DEFAULT_ROWS
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [POS_W-1:0]    req_x_start,
   input  logic [POS_W-1:0]    req_y_start,
   input  logic [SIZE_W-1:0]   req_rect_width,
   input  logic [SIZE_W-1:0]   req_rect_height,
   input  logic                req_pixel_on,
   input  logic [BYTE_W-1:0]   req_fill_byte,
   input  logic [INDEX_W-1:0]  req_read_index,
   input  queue_status_type    q_status,
   input  logic                clearing,
   output logic                push,
   output job_type             push_job
);

   localparam int BANKS = (DISPLAY_ROWS + 7) / 8;
   localparam int DEPTH = DISPLAY_COLUMNS * BANKS;
   localparam logic signed [10:0] COLS_S = 11'(DISPLAY_COLUMNS);
   localparam logic signed [10:0] ROWS_S = 11'(DISPLAY_ROWS);

   logic signed [10:0] xs, xe, xlo, xhi, xl;
   logic signed [10:0] ys, ye, ylo, yhi, yl;
   logic               rect_empty;

   // clip to the panel, ends exclusive
   always_comb begin
      xs  = {{2{req_x_start[POS_W-1]}}, req_x_start};
      ys  = {{2{req_y_start[POS_W-1]}}, req_y_start};
      xe  = xs + $signed({3'b000, req_rect_width});
      ye  = ys + $signed({3'b000, req_rect_height});
      xlo = xs[10] ? '0 : xs;
      ylo = ys[10] ? '0 : ys;
      xhi = (xe > COLS_S) ? COLS_S : xe;
      yhi = (ye > ROWS_S) ? ROWS_S : ye;
      xl  = xhi - 11'sd1;
      yl  = yhi - 11'sd1;
      rect_empty = (xhi <= xlo) || (yhi <= ylo);
   end

   always_comb begin
      push_job           = '0;
      push_job.cmd       = req_command;
      push_job.read_addr = req_read_index;
      unique case (req_command)
         CMD_RECT: begin
            push_job.kind    = rect_empty ? JOB_NONE : JOB_SWEEP;
            push_job.x_first = xlo[COORD_W-1:0];
            push_job.x_last  = xl[COORD_W-1:0];
            push_job.y_first = ylo[COORD_W-1:0];
            push_job.y_last  = yl[COORD_W-1:0];
            push_job.value   = {BYTE_W{req_pixel_on}};
         end
         CMD_FILL: begin
            // whole bytes, so the rows below a partial last bank go too
            push_job.kind    = JOB_SWEEP;
            push_job.x_first = '0;
            push_job.x_last  = COORD_W'(DISPLAY_COLUMNS - 1);
            push_job.y_first = '0;
            push_job.y_last  = COORD_W'(BANKS * 8 - 1);
            push_job.value   = req_fill_byte;
         end
         CMD_READ: begin
            push_job.kind     = JOB_READ;
            push_job.read_hit = (int'(req_read_index) < DEPTH);
         end
         CMD_NONE: begin
            push_job.kind = JOB_NONE;
         end
      endcase
   end

   assign req_ready = !q_status.full && !clearing;
   assign push      = req_valid && req_ready;

endmodule

FILE: src/mfb_queue.sv
`timescale 1ns / 1ps

module mfb_queue
   import mfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   // two-entry FIFO between front and back
   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

FILE: src/mfb_back.sv
`timescale 1ns / 1ps

module mfb_back
   import mfb_pkg::*;
#(
   parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
   parameter int DISPLAY_ROWS    = DEFAULT_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  job_type             head,
   input  queue_status_type    q_status,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic [CMD_W-1:0]    rsp_finished_command
);

   localparam int BANKS  = (DISPLAY_ROWS + 7) / 8;
   localparam int DEPTH  = DISPLAY_COLUMNS * BANKS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic                clearing_ff, clearing_in;
   logic [COORD_W-1:0]  x_ff, x_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [ADDR_W-1:0]   base_ff, base_in;

   // write-back stage of the read-modify-write
   logic                wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0]   wb_addr_ff;
   logic [BYTE_W-1:0]   wb_mask_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff;
   logic [CMD_W-1:0]    rsp_cmd_ff;

   logic [BANK_W-1:0]   bank_first, bank_last;
   logic [2:0]          lo_bit, hi_bit;
   logic [BYTE_W-1:0]   mask;
   logic                last_x, last_bank;
   logic                rd_en, wr_en, rsp_load;
   logic [ADDR_W-1:0]   rd_addr, sweep_addr;
   logic [BYTE_W-1:0]   rd_data, wr_data, reply_data;
   job_type             clear_job;

   always_comb begin
      clear_job         = '0;
      clear_job.kind    = JOB_SWEEP;
      clear_job.x_last  = COORD_W'(DISPLAY_COLUMNS - 1);
      clear_job.y_last  = COORD_W'(BANKS * 8 - 1);
   end

   always_comb begin
      bank_first = job_ff.y_first[COORD_W-1:3];
      bank_last  = job_ff.y_last[COORD_W-1:3];
      lo_bit     = (bank_ff == bank_first) ? job_ff.y_first[2:0] : 3'd0;
      hi_bit     = (bank_ff == bank_last) ? job_ff.y_last[2:0] : 3'd7;
      mask       = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
      last_x     = (x_ff == job_ff.x_last);
      last_bank  = (bank_ff == bank_last);
      sweep_addr = base_ff + ADDR_W'(x_ff);
      rsp_load   = (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head.kind)
                  JOB_SWEEP: state_in = ST_SETUP;
                  JOB_READ:  state_in = ST_READ;
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_SETUP: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (last_x && last_bank) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = clearing_ff ? ST_IDLE : ST_REPLY;
         ST_READ:  state_in = ST_REPLY;
         ST_REPLY: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop     = 1'b0;
      rd_en   = 1'b0;
      rd_addr = sweep_addr;
      unique case (state_ff)
         ST_IDLE:  pop = !q_status.empty;
         ST_SWEEP: rd_en = 1'b1;
         ST_READ: begin
            rd_en   = job_ff.read_hit;
            rd_addr = ADDR_W'(job_ff.read_addr);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // sweep counters and job register
   always_comb begin
      job_in      = pop ? head : job_ff;
      clearing_in = (state_ff == ST_DRAIN) ? 1'b0 : clearing_ff;
      x_in        = x_ff;
      bank_in     = bank_ff;
      base_in     = base_ff;
      if (state_ff == ST_SETUP) begin
         x_in    = job_ff.x_first;
         bank_in = bank_first;
         base_in = ADDR_W'(bank_first * DISPLAY_COLUMNS);
      end else if (state_ff == ST_SWEEP) begin
         if (last_x) begin
            x_in = job_ff.x_first;
            if (!last_bank) begin
               bank_in = bank_ff + BANK_W'(1);
               base_in = base_ff + ADDR_W'(DISPLAY_COLUMNS);
            end
         end else begin
            x_in = x_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SETUP;
         clearing_ff <= 1'b1;
         job_ff      <= clear_job;
      end else begin
         state_ff    <= state_in;
         clearing_ff <= clearing_in;
         job_ff      <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      bank_ff <= bank_in;
      base_ff <= base_in;
   end

   assign wb_valid_in = (state_ff == ST_SWEEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= sweep_addr;
      wb_mask_ff <= mask;
   end

   assign wr_en   = wb_valid_ff;
   assign wr_data = (rd_data & ~wb_mask_ff) | (job_ff.value & wb_mask_ff);

   mfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wb_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_comb begin
      reply_data = ((job_ff.kind == JOB_READ) && job_ff.read_hit) ? rd_data : '0;
      if ((state_ff == ST_REPLY) && rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_REPLY) && rsp_load) begin
         rsp_data_ff <= reply_data;
         rsp_cmd_ff  <= job_ff.cmd;
      end
   end

   assign clearing             = clearing_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_data_ff;
   assign rsp_finished_command = rsp_cmd_ff;

endmodule

FILE: src/mono_framebuffer_rect_fill_top.sv
`timescale 1ns / 1ps
// Replies: a read or no-op word is answered once the back end takes it from the queue; a
//   rectangle or fill is answered after it sweeps each covered column of each covered bank.
// Throughput: one read-modify-write of one store byte per cycle in the back end;
//   a 2-word queue lets new words be accepted while a command is executing.
// Reset: synchronous, active high; a clearing pass then zeroes the store, with
//   req_ready held low throughout.

module mono_framebuffer_rect_fill_top
   import mfb_pkg::*;
#(
   parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
   parameter int DISPLAY_ROWS    = DEFAULT_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [POS_W-1:0]    req_x_start,
   input  logic [POS_W-1:0]    req_y_start,
   input  logic [SIZE_W-1:0]   req_rect_width,
   input  logic [SIZE_W-1:0]   req_rect_height,
   input  logic                req_pixel_on,
   input  logic [BYTE_W-1:0]   req_fill_byte,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic [CMD_W-1:0]    rsp_finished_command
);

   // Front end: clips the rectangle to the panel and turns each word into
   // a job (byte sweep, single read, or nothing but a reply).
   // Back end: sweeps banks then columns over the store, one byte a cycle,
   // writing each byte back in the cycle after its read.

   queue_status_type q_status;
   logic             push, pop, clearing;
   job_type          push_job, head;

   mfb_front #(
      .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
      .DISPLAY_ROWS    (DISPLAY_ROWS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_pixel_on    (req_pixel_on),
      .req_fill_byte   (req_fill_byte),
      .req_read_index  (req_read_index),
      .q_status        (q_status),
      .clearing        (clearing),
      .push            (push),
      .push_job        (push_job)
   );

   // short queue so front and back stall independently
   mfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   mfb_back #(
      .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
      .DISPLAY_ROWS    (DISPLAY_ROWS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .q_status             (q_status),
      .pop                  (pop),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_finished_command (rsp_finished_command)
   );

endmodule
